[rtl/prr_pkg.sv]
// Shared types, widths and helper functions for the pinhole reprojection residual block.
package prr_pkg;

   localparam int PC_W  = 52;
   localparam int DEN_W = 51;
   localparam int XN_W  = 38;
   localparam int A12_W = 40;
   localparam int ACC_W = 58;
   localparam int PIX_W = 24;

   typedef enum logic [2:0] {
      CSR_ROT_ROW0        = 3'd0,
      CSR_ROT_ROW1        = 3'd1,
      CSR_ROT_ROW2        = 3'd2,
      CSR_TRANS_X         = 3'd3,
      CSR_TRANS_Y         = 3'd4,
      CSR_TRANS_Z         = 3'd5,
      CSR_FOCAL_PAIR      = 3'd6,
      CSR_CENTER_AND_SKEW = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [PIX_W-1:0]   obs_u;
      logic [PIX_W-1:0]   obs_v;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_u;
      logic signed [31:0] res_v;
      logic signed [31:0] jac_00;
      logic signed [31:0] jac_01;
      logic signed [31:0] jac_02;
      logic signed [31:0] jac_10;
      logic signed [31:0] jac_11;
      logic signed [31:0] jac_12;
      logic               depth_invalid;
   } rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] obs_u;
      logic [PIX_W-1:0] obs_v;
      logic             depth_invalid;
      logic [DEN_W-1:0] den;
   } mid_type;

   typedef struct packed {
      logic signed [31:0] res_u;
      logic signed [31:0] res_v;
      logic               depth_invalid;
   } tail_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] rot_entry(input logic [47:0] row, input int col);
      logic signed [15:0] e;
      e = row[16*col +: 16];
      return e;
   endfunction

endpackage

[rtl/prr_div.sv]
// Pipelined restoring divider: rounded, saturated signed quotient, one quotient bit per stage.
module prr_div #(
   parameter int NUM_W = 52,
   parameter int DEN_W = 51,
   parameter int SH    = 25,
   parameter int OUT_W = 38,
   parameter int SB_W  = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    vld_i,
   input  logic signed [NUM_W-1:0] num_i,
   input  logic [DEN_W-1:0]        den_i,
   input  logic [SB_W-1:0]         sb_i,
   output logic                    vld_o,
   output logic signed [OUT_W-1:0] quo_o,
   output logic [SB_W-1:0]         sb_o
);

   localparam int QW    = OUT_W + 1;
   localparam int LOW_W = QW - SH;
   localparam int CMP_W = NUM_W + DEN_W;

   logic [DEN_W-1:0] rem_ff  [0:QW];
   logic [QW-1:0]    bits_ff [0:QW];
   logic [QW-1:0]    q_ff    [0:QW];
   logic [DEN_W-1:0] den_ff  [0:QW];
   logic [SB_W-1:0]  sb_ff   [0:QW];
   logic [QW:0]      neg_ff;
   logic [QW:0]      ovf_ff;
   logic [QW:0]      vld_ff;

   logic [NUM_W-1:0] mag_in;
   logic [NUM_W-1:0] hi_in;

   assign mag_in = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
   assign hi_in  = mag_in >> LOW_W;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DEN_W'(hi_in);
         bits_ff[0] <= {mag_in[LOW_W-1:0], {SH{1'b0}}};
         q_ff[0]    <= '0;
         den_ff[0]  <= den_i;
         sb_ff[0]   <= sb_i;
         neg_ff[0]  <= num_i[NUM_W-1];
         ovf_ff[0]  <= CMP_W'(hi_in) >= CMP_W'(den_i);
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      logic [DEN_W:0] trial_in;
      logic           ge_in;
      assign trial_in = {rem_ff[k-1], bits_ff[k-1][QW-1]};
      assign ge_in    = trial_in >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge_in ? DEN_W'(trial_in - {1'b0, den_ff[k-1]}) : DEN_W'(trial_in);
            bits_ff[k] <= {bits_ff[k-1][QW-2:0], 1'b0};
            q_ff[k]    <= {q_ff[k-1][QW-2:0], ge_in};
            den_ff[k]  <= den_ff[k-1];
            sb_ff[k]   <= sb_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW-1:0], vld_i};
      end
   end

   logic [QW:0]             sum_in;
   logic [QW-1:0]           qr_in;
   logic [QW-1:0]           lim_in;
   logic [QW-1:0]           qs_in;
   logic signed [OUT_W-1:0] quo_in;
   logic signed [OUT_W-1:0] quo_ff;
   logic [SB_W-1:0]         sb_out_ff;
   logic                    vld_out_ff;

   assign sum_in = {1'b0, q_ff[QW]} + (QW+1)'(1);
   assign qr_in  = sum_in[QW:1];
   assign lim_in = {{(QW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}} + QW'(neg_ff[QW]);
   assign qs_in  = (ovf_ff[QW] || (qr_in > lim_in)) ? lim_in : qr_in;
   assign quo_in = neg_ff[QW] ? -OUT_W'(qs_in) : OUT_W'(qs_in);

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff    <= quo_in;
         sb_out_ff <= sb_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else if (en) begin
         vld_out_ff <= vld_ff[QW];
      end
   end

   assign vld_o = vld_out_ff;
   assign quo_o = quo_ff;
   assign sb_o  = sb_out_ff;

endmodule

[rtl/prr_xform.sv]
// Camera-frame transform: rotation products and translation sum over two stages.
module prr_xform (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           vld_i,
   input  prr_pkg::req_type               req_i,
   input  logic [47:0]                    rot_row0,
   input  logic [47:0]                    rot_row1,
   input  logic [47:0]                    rot_row2,
   input  logic signed [31:0]             trans_x,
   input  logic signed [31:0]             trans_y,
   input  logic signed [31:0]             trans_z,
   output logic                           vld_o,
   output logic signed [prr_pkg::PC_W-1:0] pc_x,
   output logic signed [prr_pkg::PC_W-1:0] pc_y,
   output logic signed [prr_pkg::PC_W-1:0] pc_z,
   output logic [prr_pkg::PIX_W-1:0]      obs_u,
   output logic [prr_pkg::PIX_W-1:0]      obs_v
);

   localparam int PC_W = prr_pkg::PC_W;

   logic [47:0]              rows [3];
   logic signed [31:0]       pw   [3];
   logic signed [31:0]       tr   [3];
   logic signed [47:0]       prod_in [3][3];
   logic signed [47:0]       prod_ff [3][3];
   logic signed [31:0]       tr_ff   [3];
   logic [prr_pkg::PIX_W-1:0] obs_u_ff, obs_v_ff, obs_u2_ff, obs_v2_ff;
   logic signed [PC_W-1:0]   pc_in [3];
   logic signed [PC_W-1:0]   pc_ff [3];
   logic [1:0]               vld_ff;

   assign rows[0] = rot_row0;
   assign rows[1] = rot_row1;
   assign rows[2] = rot_row2;
   assign pw[0]   = req_i.point_x;
   assign pw[1]   = req_i.point_y;
   assign pw[2]   = req_i.point_z;
   assign tr[0]   = trans_x;
   assign tr[1]   = trans_y;
   assign tr[2]   = trans_z;

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         assign prod_in[i][j] = prr_pkg::rot_entry(rows[i], j) * pw[j];
      end
      assign pc_in[i] = (PC_W'(tr_ff[i]) <<< 14) + PC_W'(prod_ff[i][0])
                      + PC_W'(prod_ff[i][1]) + PC_W'(prod_ff[i][2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         tr_ff     <= tr;
         obs_u_ff  <= req_i.obs_u;
         obs_v_ff  <= req_i.obs_v;
         pc_ff     <= pc_in;
         obs_u2_ff <= obs_u_ff;
         obs_v2_ff <= obs_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], vld_i};
      end
   end

   assign vld_o = vld_ff[1];
   assign pc_x  = pc_ff[0];
   assign pc_y  = pc_ff[1];
   assign pc_z  = pc_ff[2];
   assign obs_u = obs_u2_ff;
   assign obs_v = obs_v2_ff;

endmodule

[rtl/prr_jac.sv]
// Intrinsics stage: pixel offsets, residuals and Jacobian numerators over four stages.
module prr_jac (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             vld_i,
   input  logic signed [prr_pkg::XN_W-1:0]  xn_i,
   input  logic signed [prr_pkg::XN_W-1:0]  yn_i,
   input  prr_pkg::mid_type                 mid_i,
   input  logic [47:0]                      rot_row0,
   input  logic [47:0]                      rot_row1,
   input  logic [47:0]                      rot_row2,
   input  logic [47:0]                      focal_pair,
   input  logic [63:0]                      center_and_skew,
   output logic                             vld_o,
   output logic signed [prr_pkg::ACC_W-1:0] acc_o [6],
   output logic [prr_pkg::DEN_W-1:0]        den_o,
   output prr_pkg::tail_type                tail_o
);

   localparam int A12_W = prr_pkg::A12_W;
   localparam int ACC_W = prr_pkg::ACC_W;

   function automatic logic signed [A12_W-1:0] rnd24(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] m;
      mag = v[63] ? 64'(-v) : 64'(v);
      m   = (mag + 64'h80_0000) >> 24;
      return v[63] ? -A12_W'(m) : A12_W'(m);
   endfunction

   logic signed [24:0] fx, fy;
   logic signed [24:0] cx, cy;
   logic signed [19:0] skew16;

   assign fx     = $signed({1'b0, focal_pair[23:0]});
   assign fy     = $signed({1'b0, focal_pair[47:24]});
   assign cx     = $signed({1'b0, center_and_skew[23:0]});
   assign cy     = $signed({1'b0, center_and_skew[47:24]});
   assign skew16 = $signed({center_and_skew[63:48], 4'b0000});

   logic [3:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], vld_i};
      end
   end

   // Stage 1: focal and skew products.
   logic signed [63:0] pa_ff, ps_ff, pb_ff;
   prr_pkg::mid_type   mid1_ff, mid2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= 64'(fx * xn_i);
         ps_ff   <= 64'(skew16 * yn_i);
         pb_ff   <= 64'(fy * yn_i);
         mid1_ff <= mid_i;
      end
   end

   // Stage 2: round to pixel units.
   logic signed [A12_W-1:0] a12_ff, b12_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a12_ff  <= rnd24(pa_ff + ps_ff);
         b12_ff  <= rnd24(pb_ff);
         mid2_ff <= mid1_ff;
      end
   end

   // Stage 3: residuals and the M times R products.
   logic signed [ACC_W-1:0] pr0_in [3], pr1_in [3], pr2_in [3], qr1_in [3], qr2_in [3];
   logic signed [ACC_W-1:0] pr0_ff [3], pr1_ff [3], pr2_ff [3], qr1_ff [3], qr2_ff [3];
   prr_pkg::tail_type       tail_in, tail3_ff, tail4_ff;
   logic [prr_pkg::DEN_W-1:0] den3_ff, den4_ff;

   for (genvar j = 0; j < 3; j++) begin : g_prod
      assign pr0_in[j] = ACC_W'(fx * prr_pkg::rot_entry(rot_row0, j));
      assign pr1_in[j] = ACC_W'(skew16 * prr_pkg::rot_entry(rot_row1, j));
      assign pr2_in[j] = ACC_W'(a12_ff * prr_pkg::rot_entry(rot_row2, j));
      assign qr1_in[j] = ACC_W'(fy * prr_pkg::rot_entry(rot_row1, j));
      assign qr2_in[j] = ACC_W'(b12_ff * prr_pkg::rot_entry(rot_row2, j));
   end

   assign tail_in.res_u = prr_pkg::sat32(64'(a12_ff) + 64'(cx)
                                       - 64'($signed({1'b0, mid2_ff.obs_u})));
   assign tail_in.res_v = prr_pkg::sat32(64'(b12_ff) + 64'(cy)
                                       - 64'($signed({1'b0, mid2_ff.obs_v})));
   assign tail_in.depth_invalid = mid2_ff.depth_invalid;

   always_ff @(posedge clock) begin
      if (en) begin
         pr0_ff   <= pr0_in;
         pr1_ff   <= pr1_in;
         pr2_ff   <= pr2_in;
         qr1_ff   <= qr1_in;
         qr2_ff   <= qr2_in;
         tail3_ff <= tail_in;
         den3_ff  <= mid2_ff.den;
      end
   end

   // Stage 4: Jacobian numerators.
   logic signed [ACC_W-1:0] acc_ff [6];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            acc_ff[j]     <= pr0_ff[j] + pr1_ff[j] - pr2_ff[j];
            acc_ff[3 + j] <= qr1_ff[j] - qr2_ff[j];
         end
         tail4_ff <= tail3_ff;
         den4_ff  <= den3_ff;
      end
   end

   assign vld_o  = vld_ff[3];
   assign acc_o  = acc_ff;
   assign den_o  = den4_ff;
   assign tail_o = tail4_ff;

endmodule

[rtl/pinhole_reprojection_residual.sv]
// Throughput: one item per cycle; the pipeline holds as a whole while rsp is stalled.
// The pipeline length comes from the two restoring divider levels in series, one quotient bit per stage.
// Reset (synchronous, active high) clears the valid bits and the configuration registers.
// Top level of the pinhole reprojection residual and Jacobian pipeline.
module pinhole_reprojection_residual #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prr_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata
);

   localparam int PC_W   = prr_pkg::PC_W;
   localparam int DEN_W  = prr_pkg::DEN_W;
   localparam int XN_W   = prr_pkg::XN_W;
   localparam int ACC_W  = prr_pkg::ACC_W;
   localparam int JAC_SH = COORD_FRAC_BITS + 5;
   localparam int MID_W  = $bits(prr_pkg::mid_type);
   localparam int TAIL_W = $bits(prr_pkg::tail_type);

   logic [47:0]        rot_row0_ff, rot_row1_ff, rot_row2_ff, focal_pair_ff;
   logic signed [31:0] trans_x_ff, trans_y_ff, trans_z_ff;
   logic [63:0]        center_and_skew_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row0_ff        <= '0;
         rot_row1_ff        <= '0;
         rot_row2_ff        <= '0;
         trans_x_ff         <= '0;
         trans_y_ff         <= '0;
         trans_z_ff         <= '0;
         focal_pair_ff      <= '0;
         center_and_skew_ff <= '0;
      end else if (csr_we) begin
         unique case (prr_pkg::csr_index_type'(csr_index))
            prr_pkg::CSR_ROT_ROW0:        rot_row0_ff        <= csr_wdata[47:0];
            prr_pkg::CSR_ROT_ROW1:        rot_row1_ff        <= csr_wdata[47:0];
            prr_pkg::CSR_ROT_ROW2:        rot_row2_ff        <= csr_wdata[47:0];
            prr_pkg::CSR_TRANS_X:         trans_x_ff         <= csr_wdata[31:0];
            prr_pkg::CSR_TRANS_Y:         trans_y_ff         <= csr_wdata[31:0];
            prr_pkg::CSR_TRANS_Z:         trans_z_ff         <= csr_wdata[31:0];
            prr_pkg::CSR_FOCAL_PAIR:      focal_pair_ff      <= csr_wdata[47:0];
            prr_pkg::CSR_CENTER_AND_SKEW: center_and_skew_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   logic                   xf_vld;
   logic signed [PC_W-1:0] pc_x, pc_y, pc_z;
   logic [prr_pkg::PIX_W-1:0] obs_u, obs_v;

   prr_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_i    (req_valid && req_ready),
      .req_i    (req_data),
      .rot_row0 (rot_row0_ff),
      .rot_row1 (rot_row1_ff),
      .rot_row2 (rot_row2_ff),
      .trans_x  (trans_x_ff),
      .trans_y  (trans_y_ff),
      .trans_z  (trans_z_ff),
      .vld_o    (xf_vld),
      .pc_x     (pc_x),
      .pc_y     (pc_y),
      .pc_z     (pc_z),
      .obs_u    (obs_u),
      .obs_v    (obs_v)
   );

   prr_pkg::mid_type mid_in, mid_out;
   logic [MID_W-1:0] mid_sb;
   assign mid_in.obs_u         = obs_u;
   assign mid_in.obs_v         = obs_v;
   assign mid_in.depth_invalid = (pc_z <= 0);
   assign mid_in.den           = DEN_W'(pc_z);
   assign mid_out              = prr_pkg::mid_type'(mid_sb);

   logic                   xn_vld;
   logic signed [XN_W-1:0] xn, yn;

   prr_div #(.NUM_W(PC_W), .DEN_W(DEN_W), .SH(25), .OUT_W(XN_W), .SB_W(MID_W)) u_div_xn (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vld_i (xf_vld),
      .num_i (pc_x),
      .den_i (mid_in.den),
      .sb_i  (mid_in),
      .vld_o (xn_vld),
      .quo_o (xn),
      .sb_o  (mid_sb)
   );

   prr_div #(.NUM_W(PC_W), .DEN_W(DEN_W), .SH(25), .OUT_W(XN_W), .SB_W(1)) u_div_yn (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vld_i (xf_vld),
      .num_i (pc_y),
      .den_i (mid_in.den),
      .sb_i  (1'b0),
      .vld_o (),
      .quo_o (yn),
      .sb_o  ()
   );

   logic                    jc_vld;
   logic signed [ACC_W-1:0] acc [6];
   logic [DEN_W-1:0]        jc_den;
   prr_pkg::tail_type       jc_tail, out_tail;
   logic [TAIL_W-1:0]       tail_sb;
   logic                    dv_vld;
   logic signed [31:0]      jac [6];

   prr_jac u_jac (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .vld_i           (xn_vld),
      .xn_i            (xn),
      .yn_i            (yn),
      .mid_i           (mid_out),
      .rot_row0        (rot_row0_ff),
      .rot_row1        (rot_row1_ff),
      .rot_row2        (rot_row2_ff),
      .focal_pair      (focal_pair_ff),
      .center_and_skew (center_and_skew_ff),
      .vld_o           (jc_vld),
      .acc_o           (acc),
      .den_o           (jc_den),
      .tail_o          (jc_tail)
   );

   prr_div #(.NUM_W(ACC_W), .DEN_W(DEN_W), .SH(JAC_SH), .OUT_W(32), .SB_W(TAIL_W)) u_div_j0 (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vld_i (jc_vld),
      .num_i (acc[0]),
      .den_i (jc_den),
      .sb_i  (jc_tail),
      .vld_o (dv_vld),
      .quo_o (jac[0]),
      .sb_o  (tail_sb)
   );

   for (genvar i = 1; i < 6; i++) begin : g_jdiv
      prr_div #(.NUM_W(ACC_W), .DEN_W(DEN_W), .SH(JAC_SH), .OUT_W(32), .SB_W(1)) u_div_j (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .vld_i (jc_vld),
         .num_i (acc[i]),
         .den_i (jc_den),
         .sb_i  (1'b0),
         .vld_o (),
         .quo_o (jac[i]),
         .sb_o  ()
      );
   end

   assign out_tail = prr_pkg::tail_type'(tail_sb);

   prr_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in = '0;
      rsp_in.depth_invalid = out_tail.depth_invalid;
      if (!out_tail.depth_invalid) begin
         rsp_in.res_u  = out_tail.res_u;
         rsp_in.res_v  = out_tail.res_v;
         rsp_in.jac_00 = jac[0];
         rsp_in.jac_01 = jac[1];
         rsp_in.jac_02 = jac[2];
         rsp_in.jac_10 = jac[3];
         rsp_in.jac_11 = jac[4];
         rsp_in.jac_12 = jac[5];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/prr_checker.sv]
// Port-level checks for the pinhole reprojection residual block, bound to the top level.
module prr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input prr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result item changed or vanished.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.depth_invalid |->
         rsp_data.res_u == 0 && rsp_data.res_v == 0 &&
         rsp_data.jac_00 == 0 && rsp_data.jac_01 == 0 && rsp_data.jac_02 == 0 &&
         rsp_data.jac_10 == 0 && rsp_data.jac_11 == 0 && rsp_data.jac_12 == 0)
      else $error("Item with invalid depth carries nonzero results.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("Input held off while the output side is free.");

endmodule

bind pinhole_reprojection_residual prr_checker u_prr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
